// ===== rtl/tpa_pkg.sv =====
// Shared types and constants of the triangle primitive assembler.
package tpa_pkg;

    // Width of the vertex indices that the assembler keeps and compares.
    localparam int INDEX_BITS = 32;
    // Width of the index fields on the ports and of the vertex count register.
    localparam int FIELD_BITS = 32;
    // Configuration port widths.
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 4;

    // Register indexes (byte address is four times the index).
    localparam logic [1:0] REG_PRIM_MODE    = 2'd0;
    localparam logic [1:0] REG_VERTEX_COUNT = 2'd1;
    localparam logic [1:0] REG_FLIP_WINDING = 2'd2;

    // Primitive topology.
    typedef enum logic [1:0] {
        MODE_LIST   = 2'd0,
        MODE_STRIP  = 2'd1,
        MODE_FAN    = 2'd2,
        MODE_UNSUP  = 2'd3
    } t_prim_mode;

    // Primitive status carried on the done result.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_LIST_LEN = 2'd2,
        ST_MODE     = 2'd3
    } t_status;

    // Configuration seen by the assembler.
    typedef struct packed {
        t_prim_mode             prim_mode;
        logic [FIELD_BITS-1:0]  vertex_count;
        logic                   flip_winding;
    } t_cfg;

    // One result item.
    typedef struct packed {
        logic [FIELD_BITS-1:0]  corner_a;
        logic [FIELD_BITS-1:0]  corner_b;
        logic [FIELD_BITS-1:0]  corner_c;
        logic                   tri_valid;
        logic                   done_res;
        t_status                status;
    } t_result;

endpackage

// ===== rtl/tpa_cfg_regs.sv =====
// Configuration register file with its APB-style access port.
module tpa_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tpa_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [tpa_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [tpa_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready,
    output tpa_pkg::t_cfg                       o_cfg
);

    tpa_pkg::t_prim_mode                    r_prim_mode;
    logic [tpa_pkg::FIELD_BITS-1:0]         r_vertex_count;
    logic                                   r_flip_winding;
    logic [1:0]                             w_reg_idx;
    logic                                   w_write;

    // The register index is the word address; byte offsets are ignored.
    assign w_reg_idx = paddr[3:2];
    assign w_write   = psel && penable && pwrite;
    assign pready    = 1'b1;

    // Register writes in the access phase of a write transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prim_mode    <= tpa_pkg::MODE_LIST;
            r_vertex_count <= '0;
            r_flip_winding <= 1'b0;
        end else if (w_write) begin
            unique case (w_reg_idx)
                tpa_pkg::REG_PRIM_MODE: begin
                    r_prim_mode <= tpa_pkg::t_prim_mode'(pwdata[1:0]);
                end
                tpa_pkg::REG_VERTEX_COUNT: begin
                    r_vertex_count <= pwdata[tpa_pkg::FIELD_BITS-1:0];
                end
                tpa_pkg::REG_FLIP_WINDING: begin
                    r_flip_winding <= pwdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read data mux.
    always_comb begin
        prdata = '0;
        unique case (w_reg_idx)
            tpa_pkg::REG_PRIM_MODE:    prdata[1:0] = r_prim_mode;
            tpa_pkg::REG_VERTEX_COUNT: prdata = r_vertex_count;
            tpa_pkg::REG_FLIP_WINDING: prdata[0] = r_flip_winding;
            default:                   prdata = '0;
        endcase
    end

    assign o_cfg.prim_mode    = r_prim_mode;
    assign o_cfg.vertex_count = r_vertex_count;
    assign o_cfg.flip_winding = r_flip_winding;

endmodule

// ===== rtl/tpa_assembler.sv =====
// Input register, assembly state and the combinational triangle build logic.
module tpa_assembler (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tpa_pkg::t_cfg                   i_cfg,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [tpa_pkg::FIELD_BITS-1:0]  i_vertex_index,
    input  logic                            i_is_last,
    input  logic                            i_res_space,
    output logic                            o_res_load,
    output tpa_pkg::t_result                o_res
);

    // Input register.
    logic                               r_in_valid;
    logic [tpa_pkg::INDEX_BITS-1:0]     r_in_index;
    logic                               r_in_last;

    // Assembly state.
    logic [tpa_pkg::INDEX_BITS-1:0]     r_anchor, n_anchor;
    logic [tpa_pkg::INDEX_BITS-1:0]     r_older;
    logic [tpa_pkg::INDEX_BITS-1:0]     r_newer;
    logic [1:0]                         r_seen, n_seen;
    logic [1:0]                         r_list_phase, n_list_phase;
    logic                               r_parity, n_parity;
    tpa_pkg::t_status                   r_error, w_err_range, n_error;

    // Build signals.
    logic                               w_fire;
    logic                               w_tri, w_tri_ok;
    logic [tpa_pkg::INDEX_BITS-1:0]     w_a, w_b, w_c;

    // The held item is consumed once the result register can take its result.
    assign w_fire     = r_in_valid && i_res_space;
    assign o_in_ready = !r_in_valid || w_fire;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_index <= i_vertex_index[tpa_pkg::INDEX_BITS-1:0];
            r_in_last  <= i_is_last;
        end
    end

    // Triangle build and next-state logic for the held index.
    always_comb begin
        if (r_error == tpa_pkg::ST_OK &&
            tpa_pkg::FIELD_BITS'(r_in_index) >= i_cfg.vertex_count) begin
            w_err_range = tpa_pkg::ST_RANGE;
        end else begin
            w_err_range = r_error;
        end

        w_tri        = 1'b0;
        w_a          = '0;
        w_b          = '0;
        w_c          = '0;
        n_anchor     = r_anchor;
        n_list_phase = r_list_phase;
        n_parity     = r_parity;

        case (i_cfg.prim_mode)
            tpa_pkg::MODE_LIST: begin
                if (r_list_phase == 2'd2) begin
                    w_tri        = 1'b1;
                    w_a          = r_older;
                    w_b          = r_newer;
                    w_c          = r_in_index;
                    n_list_phase = 2'd0;
                end else begin
                    n_list_phase = r_list_phase + 2'd1;
                end
            end
            tpa_pkg::MODE_STRIP: begin
                if (r_seen >= 2'd2) begin
                    w_tri    = 1'b1;
                    w_a      = r_parity ? r_newer : r_older;
                    w_b      = r_parity ? r_older : r_newer;
                    w_c      = r_in_index;
                    n_parity = !r_parity;
                end
            end
            tpa_pkg::MODE_FAN: begin
                if (r_seen == 2'd0) begin
                    n_anchor = r_in_index;
                end
                if (r_seen >= 2'd2) begin
                    w_tri = 1'b1;
                    w_a   = r_anchor;
                    w_b   = r_newer;
                    w_c   = r_in_index;
                end
            end
            default: begin
            end
        endcase

        n_seen = (r_seen == 2'd3) ? r_seen : r_seen + 2'd1;

        // No triangle once the primitive carries an error or the mode is unsupported.
        w_tri_ok = w_tri && (i_cfg.prim_mode != tpa_pkg::MODE_UNSUP) &&
                   (w_err_range == tpa_pkg::ST_OK);

        // Errors found only at the end of the primitive.
        n_error = w_err_range;
        if (r_in_last && w_err_range == tpa_pkg::ST_OK) begin
            if (i_cfg.prim_mode == tpa_pkg::MODE_LIST && n_list_phase != 2'd0) begin
                n_error = tpa_pkg::ST_LIST_LEN;
            end else if (i_cfg.prim_mode == tpa_pkg::MODE_UNSUP) begin
                n_error = tpa_pkg::ST_MODE;
            end
        end

        // Result item; the flip swaps the second and third corner.
        o_res.corner_a  = w_tri_ok ? tpa_pkg::FIELD_BITS'(w_a) : '0;
        o_res.corner_b  = w_tri_ok ?
                          tpa_pkg::FIELD_BITS'(i_cfg.flip_winding ? w_c : w_b) : '0;
        o_res.corner_c  = w_tri_ok ?
                          tpa_pkg::FIELD_BITS'(i_cfg.flip_winding ? w_b : w_c) : '0;
        o_res.tri_valid = w_tri_ok;
        o_res.done_res  = r_in_last;
        o_res.status    = n_error;
    end

    assign o_res_load = w_fire && (w_tri_ok || r_in_last);

    // Assembly state; the last index of a primitive clears everything.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anchor     <= '0;
            r_older      <= '0;
            r_newer      <= '0;
            r_seen       <= 2'd0;
            r_list_phase <= 2'd0;
            r_parity     <= 1'b0;
            r_error      <= tpa_pkg::ST_OK;
        end else if (w_fire) begin
            if (r_in_last) begin
                r_anchor     <= '0;
                r_older      <= '0;
                r_newer      <= '0;
                r_seen       <= 2'd0;
                r_list_phase <= 2'd0;
                r_parity     <= 1'b0;
                r_error      <= tpa_pkg::ST_OK;
            end else begin
                r_anchor     <= n_anchor;
                r_older      <= r_newer;
                r_newer      <= r_in_index;
                r_seen       <= n_seen;
                r_list_phase <= n_list_phase;
                r_parity     <= n_parity;
                r_error      <= n_error;
            end
        end
    end

endmodule

// ===== rtl/tpa_out_reg.sv =====
// Result register that holds one result transaction until it is taken.
module tpa_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  tpa_pkg::t_result    i_res,
    output logic                o_space,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tpa_pkg::t_result    o_res
);

    logic               r_valid;
    tpa_pkg::t_result   r_res;

    // Space whenever the register is empty or is being emptied now.
    assign o_space = !r_valid || i_out_ready;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (o_space && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_res       = r_res;

endmodule

// ===== rtl/triangle_primitive_assembly.sv =====
// Top level of the triangle primitive assembler.
// The block takes one vertex index per clock cycle while its output register has space and
// returns triangles of a list, strip or fan, with a done result on the last index that carries
// the primitive's status. An accepted index is held in the input register; its result is
// built combinationally and loaded into the output register when that register has space.
// A held result stalls intake only while the output register is full and not being taken.
// Configuration registers (mode at byte address 0, vertex count at 4, flip at 8) are to be
// written only while the block is idle; the block itself does not enforce this.
module triangle_primitive_assembly (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tpa_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [tpa_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [tpa_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready,
    // Index input.
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [tpa_pkg::FIELD_BITS-1:0]      i_vertex_index,
    input  logic                                i_is_last,
    // Result output.
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [tpa_pkg::FIELD_BITS-1:0]      o_corner_a,
    output logic [tpa_pkg::FIELD_BITS-1:0]      o_corner_b,
    output logic [tpa_pkg::FIELD_BITS-1:0]      o_corner_c,
    output logic                                o_tri_valid,
    output logic                                o_done_res,
    output logic [1:0]                          o_status
);

    tpa_pkg::t_cfg      w_cfg;
    tpa_pkg::t_result   w_res_next;
    tpa_pkg::t_result   w_res_out;
    logic               w_res_space;
    logic               w_res_load;

    tpa_cfg_regs u_cfg_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_cfg    (w_cfg)
    );

    tpa_assembler u_assembler (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_vertex_index (i_vertex_index),
        .i_is_last      (i_is_last),
        .i_res_space    (w_res_space),
        .o_res_load     (w_res_load),
        .o_res          (w_res_next)
    );

    tpa_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_res_load),
        .i_res       (w_res_next),
        .o_space     (w_res_space),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (w_res_out)
    );

    assign o_corner_a  = w_res_out.corner_a;
    assign o_corner_b  = w_res_out.corner_b;
    assign o_corner_c  = w_res_out.corner_c;
    assign o_tri_valid = w_res_out.tri_valid;
    assign o_done_res  = w_res_out.done_res;
    assign o_status    = w_res_out.status;

    // A result without a triangle is only ever the done result.
    a_no_tri_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_tri_valid) |-> o_done_res)
        else $error("result without triangle and without done mark");

    // A triangle is only emitted by a primitive that is still clean.
    a_tri_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_tri_valid) |-> (o_status == tpa_pkg::ST_OK))
        else $error("triangle emitted with a nonzero status");

    // Corners read as zero when no triangle is carried.
    a_idle_corners_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_tri_valid) |->
            (o_corner_a == '0 && o_corner_b == '0 && o_corner_c == '0))
        else $error("corner fields not zero on a done-only result");

endmodule

// ===== bench/triangle_primitive_assembly_test.sv =====
// Self-checking testbench for the triangle primitive assembler.
module triangle_primitive_assembly_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 150000;
    localparam int DRAIN_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1150;
    localparam logic [31:0] IDX_MASK = 32'((64'd1 << tpa_pkg::INDEX_BITS) - 64'd1);

    // One vertex index waiting to be sent.
    typedef struct packed {
        logic [31:0] vidx;
        logic        last;
    } t_index_item;

    logic                                   i_clk;
    logic                                   i_rst_n;
    logic                                   psel;
    logic                                   penable;
    logic                                   pwrite;
    logic [tpa_pkg::APB_ADDR_BITS-1:0]      paddr;
    logic [tpa_pkg::APB_DATA_BITS-1:0]      pwdata;
    logic [tpa_pkg::APB_DATA_BITS-1:0]      prdata;
    logic                                   pready;
    logic                                   i_in_valid;
    logic                                   o_in_ready;
    logic [tpa_pkg::FIELD_BITS-1:0]         i_vertex_index;
    logic                                   i_is_last;
    logic                                   o_out_valid;
    logic                                   i_out_ready;
    logic [tpa_pkg::FIELD_BITS-1:0]         o_corner_a;
    logic [tpa_pkg::FIELD_BITS-1:0]         o_corner_b;
    logic [tpa_pkg::FIELD_BITS-1:0]         o_corner_c;
    logic                                   o_tri_valid;
    logic                                   o_done_res;
    logic [1:0]                             o_status;

    triangle_primitive_assembly dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_vertex_index (i_vertex_index),
        .i_is_last      (i_is_last),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_corner_a     (o_corner_a),
        .o_corner_b     (o_corner_b),
        .o_corner_c     (o_corner_c),
        .o_tri_valid    (o_tri_valid),
        .o_done_res     (o_done_res),
        .o_status       (o_status)
    );

    // Configuration as the assembler currently holds it.
    tpa_pkg::t_prim_mode  cfg_mode;
    logic [31:0]          cfg_count;
    logic                 cfg_flip;

    // Assembly state of the predictor.
    logic [31:0]          asm_anchor;
    logic [31:0]          asm_older;
    logic [31:0]          asm_newer;
    logic [1:0]           asm_seen;
    logic [1:0]           asm_phase;
    logic                 asm_odd;
    tpa_pkg::t_status     asm_status;

    // Both queues take new entries at the front and hand out the oldest from the back.
    t_index_item          pending_idx[$];
    tpa_pkg::t_result     awaited_results[$];

    int          idx_launched;
    int          idx_taken;
    int          send_gap;
    int          recv_gap;
    bit          idle_on;
    int          items_queued;
    int          cycle_cnt;
    int          mismatches;
    int          tris_seen;
    int          done_by_status[4];

    // Free-running clock.
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Clear the assembly state, as after a done result.
    task automatic clear_assembly();
        asm_anchor = '0;
        asm_older  = '0;
        asm_newer  = '0;
        asm_seen   = '0;
        asm_phase  = '0;
        asm_odd    = 1'b0;
        asm_status = tpa_pkg::ST_OK;
    endtask

    // Advance the assembly by one accepted index and queue any result it causes.
    task automatic assemble_index(input logic [31:0] raw_idx, input logic last);
        logic [31:0]      cur;
        logic [31:0]      ca;
        logic [31:0]      cb;
        logic [31:0]      cc;
        logic [31:0]      swap;
        logic             tri_ok;
        tpa_pkg::t_result res;
        cur    = raw_idx & IDX_MASK;
        ca     = '0;
        cb     = '0;
        cc     = '0;
        tri_ok = 1'b0;
        // The first error of a primitive is the one that sticks.
        if (asm_status == tpa_pkg::ST_OK && cur >= cfg_count) begin
            asm_status = tpa_pkg::ST_RANGE;
        end
        case (cfg_mode)
            tpa_pkg::MODE_LIST: begin
                if (asm_phase == 2'd2) begin
                    ca = asm_older;
                    cb = asm_newer;
                    cc = cur;
                    tri_ok = 1'b1;
                    asm_phase = 2'd0;
                end else begin
                    asm_phase = asm_phase + 2'd1;
                end
            end
            tpa_pkg::MODE_STRIP: begin
                if (asm_seen >= 2'd2) begin
                    // Odd strip triangles swap their first two corners.
                    ca = asm_odd ? asm_newer : asm_older;
                    cb = asm_odd ? asm_older : asm_newer;
                    cc = cur;
                    tri_ok = 1'b1;
                    asm_odd = ~asm_odd;
                end
            end
            tpa_pkg::MODE_FAN: begin
                if (asm_seen == 2'd0) begin
                    asm_anchor = cur;
                end
                if (asm_seen >= 2'd2) begin
                    ca = asm_anchor;
                    cb = asm_newer;
                    cc = cur;
                    tri_ok = 1'b1;
                end
            end
            default: begin
            end
        endcase
        asm_older = asm_newer;
        asm_newer = cur;
        if (asm_seen < 2'd3) begin
            asm_seen = asm_seen + 2'd1;
        end
        if (cfg_mode == tpa_pkg::MODE_UNSUP || asm_status != tpa_pkg::ST_OK) begin
            tri_ok = 1'b0;
        end
        if (tri_ok && cfg_flip) begin
            swap = cb;
            cb = cc;
            cc = swap;
        end
        // Length and mode errors are only known at the last index.
        if (last && asm_status == tpa_pkg::ST_OK) begin
            if (cfg_mode == tpa_pkg::MODE_LIST && asm_phase != 2'd0) begin
                asm_status = tpa_pkg::ST_LIST_LEN;
            end else if (cfg_mode == tpa_pkg::MODE_UNSUP) begin
                asm_status = tpa_pkg::ST_MODE;
            end
        end
        if (tri_ok || last) begin
            res.corner_a  = tri_ok ? ca : '0;
            res.corner_b  = tri_ok ? cb : '0;
            res.corner_c  = tri_ok ? cc : '0;
            res.tri_valid = tri_ok;
            res.done_res  = last;
            res.status    = asm_status;
            awaited_results.push_front(res);
        end
        if (last) begin
            clear_assembly();
        end
    endtask

    // Report one field that differs from its prediction.
    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, fname, want, got);
            mismatches++;
        end
    endtask

    // Monitor: predicts on every accepted index and checks every accepted result.
    always @(posedge i_clk) begin : monitor
        tpa_pkg::t_result exp_res;
        cycle_cnt++;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                assemble_index(i_vertex_index, i_is_last);
                idx_taken <= idx_taken + 1;
            end
            if (o_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    $display({"%0t ns: result with no transaction expected, expected none,",
                              " actual %h %h %h tri %b done %b status %0d"},
                             $time, o_corner_a, o_corner_b, o_corner_c,
                             o_tri_valid, o_done_res, o_status);
                    mismatches++;
                end else begin
                    exp_res = awaited_results.pop_back();
                    check_field("corner_a", exp_res.corner_a, o_corner_a);
                    check_field("corner_b", exp_res.corner_b, o_corner_b);
                    check_field("corner_c", exp_res.corner_c, o_corner_c);
                    check_field("tri_valid", {31'd0, exp_res.tri_valid}, {31'd0, o_tri_valid});
                    check_field("done_res", {31'd0, exp_res.done_res}, {31'd0, o_done_res});
                    check_field("status", {30'd0, exp_res.status}, {30'd0, o_status});
                end
                if (o_tri_valid === 1'b1) begin
                    tris_seen++;
                end
                if (o_done_res === 1'b1) begin
                    done_by_status[o_status]++;
                end
            end
        end
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t ns: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // Driver: sends queued indices and throttles the result side.
    always @(negedge i_clk) begin : driver
        t_index_item nxt;
        if (!i_in_valid || idx_taken == idx_launched) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pending_idx.size() != 0) begin
                nxt = pending_idx.pop_back();
                i_vertex_index <= nxt.vidx;
                i_is_last <= nxt.last;
                i_in_valid <= 1'b1;
                idx_launched <= idx_launched + 1;
                if (idle_on && $urandom_range(5, 0) == 0) begin
                    send_gap <= $urandom_range(4, 1);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (idle_on && $urandom_range(5, 0) == 0) begin
                recv_gap <= $urandom_range(4, 1);
            end
        end
    end

    // Queue one index for the driver.
    task automatic push_index(input logic [31:0] vidx, input logic last);
        t_index_item item;
        item.vidx = vidx;
        item.last = last;
        pending_idx.push_front(item);
        items_queued++;
    endtask

    // Register access over the configuration port: setup cycle, then access cycle.
    task automatic apb_access(input logic [1:0] reg_idx, input logic wr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= tpa_pkg::APB_ADDR_BITS'({reg_idx, 2'b00});
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write one register, read it back and track it in the predictor.
    task automatic write_reg(input logic [1:0] reg_idx, input logic [31:0] value);
        logic [31:0] rd;
        apb_access(reg_idx, 1'b1, value, rd);
        apb_access(reg_idx, 1'b0, '0, rd);
        if (rd !== value) begin
            $display("%0t ns: register %0d readback mismatch, expected %h, actual %h",
                     $time, reg_idx, value, rd);
            mismatches++;
        end
        case (reg_idx)
            tpa_pkg::REG_PRIM_MODE:    cfg_mode  = tpa_pkg::t_prim_mode'(value[1:0]);
            tpa_pkg::REG_VERTEX_COUNT: cfg_count = value;
            default:                   cfg_flip  = value[0];
        endcase
    endtask

    // Set up all three registers for the next phase.
    task automatic program_config(input tpa_pkg::t_prim_mode mode, input logic [31:0] count,
                                  input logic flip);
        write_reg(tpa_pkg::REG_PRIM_MODE, {30'd0, mode});
        write_reg(tpa_pkg::REG_VERTEX_COUNT, count);
        write_reg(tpa_pkg::REG_FLIP_WINDING, {31'd0, flip});
    endtask

    // Hold off until the sender is empty and every expected result has come.
    task automatic wait_idle();
        int waited;
        waited = 0;
        while (pending_idx.size() != 0 || i_in_valid) begin
            @(posedge i_clk);
        end
        while (awaited_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (awaited_results.size() != 0) begin
            $display("%0t ns: missing results, expected %0d more, actual none",
                     $time, awaited_results.size());
            mismatches++;
            awaited_results.delete();
        end
        // Let an index that causes no result clear the pipeline.
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly in-range index, with the occasional out-of-range or boundary value.
    function automatic logic [31:0] pick_index(input logic [31:0] count);
        int roll;
        roll = $urandom_range(59, 0);
        if (count == 0 || roll == 0) begin
            return $urandom;
        end
        if (roll == 1) begin
            return count;
        end
        if (roll == 2) begin
            return count - 32'd1;
        end
        return $urandom_range(count - 32'd1, 0);
    endfunction

    // Queue one primitive of the given length with random indices.
    task automatic queue_primitive(input int len);
        for (int i = 0; i < len; i++) begin
            push_index(pick_index(cfg_count), i == len - 1);
        end
    endtask

    // Stimulus: directed cases, then random phases, each with its own settings.
    initial begin : stimulus
        int                   roll;
        int                   nprims;
        int                   len;
        int                   phases;
        tpa_pkg::t_prim_mode  mode;
        logic [31:0]          count;
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        i_in_valid     = 1'b0;
        i_vertex_index = '0;
        i_is_last      = 1'b0;
        i_out_ready    = 1'b0;
        idx_launched   = 0;
        idx_taken      = 0;
        send_gap       = 0;
        recv_gap       = 0;
        idle_on        = 1'b1;
        items_queued   = 0;
        cycle_cnt      = 0;
        mismatches     = 0;
        tris_seen      = 0;
        phases         = 0;
        for (int s = 0; s < 4; s++) begin
            done_by_status[s] = 0;
        end
        cfg_mode  = tpa_pkg::MODE_LIST;
        cfg_count = '0;
        cfg_flip  = 1'b0;
        clear_assembly();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // List with extreme indices, a short list and an out-of-range index.
        program_config(tpa_pkg::MODE_LIST, 32'hFFFF_FFFF, 1'b0);
        push_index(32'h0, 0); push_index(32'hFFFF_FFFE, 0); push_index(32'h1234_5678, 0);
        push_index(32'h1, 0); push_index(32'h2, 0); push_index(32'h3, 1);
        push_index(32'h5, 0); push_index(32'h6, 1);
        push_index(32'hFFFF_FFFF, 0); push_index(32'h1, 0); push_index(32'h2, 1);
        wait_idle();
        // Strip with flipped winding, then a strip too short for a triangle.
        program_config(tpa_pkg::MODE_STRIP, 32'd16, 1'b1);
        push_index(32'd1, 0); push_index(32'd2, 0); push_index(32'd3, 0);
        push_index(32'd4, 1);
        push_index(32'd7, 0); push_index(32'd8, 1);
        wait_idle();
        // Fan ending on the highest legal index.
        program_config(tpa_pkg::MODE_FAN, 32'd16, 1'b0);
        push_index(32'd9, 0); push_index(32'd10, 0); push_index(32'd11, 0);
        push_index(32'd15, 1);
        wait_idle();
        // Unsupported mode, then a range error that wins over the mode error.
        program_config(tpa_pkg::MODE_UNSUP, 32'd16, 1'b0);
        push_index(32'd1, 0); push_index(32'd2, 0); push_index(32'd3, 1);
        wait_idle();
        program_config(tpa_pkg::MODE_UNSUP, 32'd0, 1'b0);
        push_index(32'd0, 1);
        wait_idle();

        // Random phases; the last stretch runs without idling.
        while (items_queued < RANDOM_ITEMS) begin
            roll = $urandom_range(9, 0);
            mode = (roll < 3) ? tpa_pkg::MODE_LIST : (roll < 6) ? tpa_pkg::MODE_STRIP :
                   (roll < 9) ? tpa_pkg::MODE_FAN : tpa_pkg::MODE_UNSUP;
            roll = $urandom_range(15, 0);
            if (roll == 0) begin
                count = 32'd0;
            end else if (roll <= 2) begin
                count = 32'hFFFF_FFFF;
            end else if (roll <= 7) begin
                count = $urandom_range(64, 1);
            end else begin
                count = $urandom;
            end
            program_config(mode, count, 1'($urandom_range(1, 0)));
            idle_on = (items_queued < RANDOM_ITEMS - 150) && ($urandom_range(3, 0) != 0);
            nprims = $urandom_range(12, 4);
            for (int p = 0; p < nprims; p++) begin
                if (items_queued >= RANDOM_ITEMS) begin
                    break;
                end
                case (cfg_mode)
                    tpa_pkg::MODE_LIST: len = ($urandom_range(7, 0) == 0) ?
                                     $urandom_range(10, 1) : 3 * $urandom_range(5, 1);
                    tpa_pkg::MODE_UNSUP: len = $urandom_range(5, 1);
                    default: len = ($urandom_range(7, 0) == 0) ?
                                   $urandom_range(2, 1) : $urandom_range(14, 3);
                endcase
                queue_primitive(len);
                // Sometimes let the block drain fully in the middle of a phase.
                if (p == nprims / 2 && $urandom_range(2, 0) == 0) begin
                    wait_idle();
                end
            end
            wait_idle();
            phases++;
        end

        $display("Ran %0d indices over %0d random phases plus directed cases;",
                 items_queued, phases);
        $display("%0d triangles checked.", tris_seen);
        $display("Primitive status: ok %0d, out of range %0d, bad list length %0d, unsupported %0d.",
                 done_by_status[tpa_pkg::ST_OK], done_by_status[tpa_pkg::ST_RANGE],
                 done_by_status[tpa_pkg::ST_LIST_LEN], done_by_status[tpa_pkg::ST_MODE]);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
